FILE: rtl/sdplr_pkg.sv
// ----------------------------------------------------------------------------
// sdplr_pkg
// Shared types and constants of the session description line recogniser:
// transfer payloads, result kinds, line status codes and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sdplr_pkg;

	// Token counts required on o= and c= lines
	localparam logic [2:0] ORIGIN_FIELDS     = 3'd6;
	localparam logic [2:0] CONNECTION_FIELDS = 3'd3;

	// Width of the saturating line counter
	localparam int LINE_COUNT_BITS = 16;

	// Most results one input byte can produce
	localparam int MAX_RES = 4;
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	// Result kinds
	localparam logic [1:0] RK_VALUE    = 2'd0;
	localparam logic [1:0] RK_LINE_END = 2'd1;
	localparam logic [1:0] RK_END      = 2'd2;

	// Line status codes
	localparam logic [2:0] LS_OK          = 3'd0;
	localparam logic [2:0] LS_MALFORMED   = 3'd1;
	localparam logic [2:0] LS_UNSUPPORTED = 3'd2;
	localparam logic [2:0] LS_TOKEN_COUNT = 3'd3;
	localparam logic [2:0] LS_EMPTY_NAME  = 3'd4;
	localparam logic [2:0] LS_END         = 3'd5;

	// Input transfer payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} sdplr_in_t;

	// Output transfer payload
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  line_type;
		logic [7:0]  value_byte;
		logic [2:0]  field_index;
		logic        is_separator;
		logic [15:0] line_number;
		logic [2:0]  line_status;
		logic        last_of_run;
	} sdplr_res_t;

	// All results caused by one input byte, item 0 first
	typedef struct packed {
		logic [RES_CNT_W-1:0]            cnt;
		sdplr_res_t [MAX_RES-1:0]        item;
	} sdplr_bundle_t;

endpackage

`default_nettype wire

FILE: rtl/sdplr_step.sv
// ----------------------------------------------------------------------------
// sdplr_step
// Line parsing state and the single-pass logic that turns one byte into its
// bundle of results and the next parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module sdplr_step
	import sdplr_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire sdplr_in_t     byte_in,
	output sdplr_bundle_t      bundle
);

	// Character codes
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_V = "v";
	localparam logic [7:0] CH_O = "o";
	localparam logic [7:0] CH_S = "s";
	localparam logic [7:0] CH_I = "i";
	localparam logic [7:0] CH_U = "u";
	localparam logic [7:0] CH_E = "e";
	localparam logic [7:0] CH_P = "p";
	localparam logic [7:0] CH_C = "c";
	localparam logic [7:0] CH_B = "b";
	localparam logic [7:0] CH_T = "t";
	localparam logic [7:0] CH_R = "r";
	localparam logic [7:0] CH_Z = "z";
	localparam logic [7:0] CH_K = "k";
	localparam logic [7:0] CH_A = "a";
	localparam logic [7:0] CH_M = "m";

	// Pending line error codes
	localparam logic [1:0] PE_NONE        = 2'd0;
	localparam logic [1:0] PE_MALFORMED   = 2'd1;
	localparam logic [1:0] PE_UNSUPPORTED = 2'd2;
	localparam logic [1:0] PE_TOKENS      = 2'd3;

	localparam int LINE_EXT_W = (LINE_COUNT_BITS > 16) ? LINE_COUNT_BITS : 16;

	typedef enum logic [3:0] {
		PH_START   = 4'b0001,
		PH_TYPE    = 4'b0010,
		PH_VALUE   = 4'b0100,
		PH_DISCARD = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t                     phase;
		logic [7:0]                 type_letter;
		logic                       cr_held;
		logic [LINE_COUNT_BITS-1:0] line_cnt;
		logic [2:0]                 tokens;
		logic                       in_token;
		logic                       colon_seen;
		logic                       name_nonempty;
		logic [1:0]                 pend_err;
	} state_t;

	localparam state_t STATE_RST = '{
		phase:         PH_START,
		type_letter:   8'd0,
		cr_held:       1'b0,
		line_cnt:      '0,
		tokens:        3'd0,
		in_token:      1'b0,
		colon_seen:    1'b0,
		name_nonempty: 1'b0,
		pend_err:      PE_NONE
	};

	state_t state_q;
	state_t st_next;

	function automatic logic type_valid(input logic [7:0] t);
		logic ok;
		case (t) inside
			CH_V, CH_O, CH_S, CH_I, CH_U, CH_E, CH_P, CH_C,
			CH_B, CH_T, CH_R, CH_Z, CH_K, CH_A, CH_M: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Append one result; the line number is the counter capped at 16 bits
	function automatic void emit(inout sdplr_bundle_t bd, input state_t st,
			input logic [1:0] kind, input logic [7:0] ltype,
			input logic [7:0] vbyte, input logic [2:0] idx,
			input logic sep, input logic [2:0] status);
		sdplr_res_t             r;
		logic [LINE_EXT_W-1:0]  ext;
		ext = LINE_EXT_W'(st.line_cnt);
		r.result_kind  = kind;
		r.line_type    = ltype;
		r.value_byte   = vbyte;
		r.field_index  = idx;
		r.is_separator = sep;
		r.line_number  = (ext > LINE_EXT_W'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
		r.line_status  = status;
		r.last_of_run  = 1'b0;
		if (bd.cnt < RES_CNT_W'(MAX_RES)) begin
			bd.item[bd.cnt[$clog2(MAX_RES)-1:0]] = r;
			bd.cnt = bd.cnt + RES_CNT_W'(1);
		end
	endfunction

	function automatic void count_line(inout state_t st);
		if (st.line_cnt != '1) begin
			st.line_cnt = st.line_cnt + LINE_COUNT_BITS'(1);
		end
	endfunction

	function automatic void clear_line(inout state_t st);
		st.phase         = PH_START;
		st.tokens        = 3'd0;
		st.in_token      = 1'b0;
		st.colon_seen    = 1'b0;
		st.name_nonempty = 1'b0;
		st.pend_err      = PE_NONE;
	endfunction

	// Space-separated token tracking for o= and c= lines
	function automatic void token_byte(inout state_t st, inout sdplr_bundle_t bd,
			input logic [7:0] b, input logic [2:0] limit);
		logic [2:0] idx;
		if (b == CH_SPACE) begin
			st.in_token = 1'b0;
			emit(bd, st, RK_VALUE, st.type_letter, b, st.tokens, 1'b1, LS_OK);
		end else begin
			if (!st.in_token) begin
				st.in_token = 1'b1;
				if (st.tokens < limit) begin
					st.tokens = st.tokens + 3'd1;
				end else begin
					st.pend_err = PE_TOKENS;
				end
			end
			idx = (st.pend_err == PE_TOKENS) ? 3'd7 : st.tokens - 3'd1;
			emit(bd, st, RK_VALUE, st.type_letter, b, idx, 1'b0, LS_OK);
		end
	endfunction

	// One byte of line content
	function automatic void proc_byte(inout state_t st, inout sdplr_bundle_t bd,
			input logic [7:0] b);
		unique case (st.phase)
			PH_START: begin
				count_line(st);
				st.type_letter = b;
				st.phase       = PH_TYPE;
			end
			PH_TYPE: begin
				if (b != CH_EQ) begin
					st.phase    = PH_DISCARD;
					st.pend_err = PE_MALFORMED;
				end else if (!type_valid(st.type_letter)) begin
					st.phase    = PH_DISCARD;
					st.pend_err = PE_UNSUPPORTED;
				end else if (st.type_letter == CH_K) begin
					st.phase    = PH_DISCARD;
					st.pend_err = PE_NONE;
				end else begin
					st.phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (st.type_letter == CH_O) begin
					token_byte(st, bd, b, ORIGIN_FIELDS);
				end else if (st.type_letter == CH_C) begin
					token_byte(st, bd, b, CONNECTION_FIELDS);
				end else if (st.type_letter == CH_A) begin
					if (!st.colon_seen && b == CH_COLON) begin
						st.colon_seen = 1'b1;
						emit(bd, st, RK_VALUE, st.type_letter, b, 3'd1, 1'b1, LS_OK);
					end else if (!st.colon_seen) begin
						st.name_nonempty = 1'b1;
						emit(bd, st, RK_VALUE, st.type_letter, b, 3'd0, 1'b0, LS_OK);
					end else begin
						emit(bd, st, RK_VALUE, st.type_letter, b, 3'd1, 1'b0, LS_OK);
					end
				end else begin
					emit(bd, st, RK_VALUE, st.type_letter, b, 3'd0, 1'b0, LS_OK);
				end
			end
			PH_DISCARD: begin
			end
			default: begin
			end
		endcase
	endfunction

	// Close the open line with its status
	function automatic void end_line(inout state_t st, inout sdplr_bundle_t bd);
		logic [2:0] status;
		status = LS_OK;
		unique case (st.phase)
			PH_START: begin
				count_line(st);
			end
			PH_TYPE: begin
				emit(bd, st, RK_LINE_END, st.type_letter, 8'd0, 3'd0, 1'b0, LS_MALFORMED);
			end
			PH_VALUE: begin
				if (st.type_letter == CH_O) begin
					status = (st.pend_err != PE_TOKENS && st.tokens == ORIGIN_FIELDS) ?
						LS_OK : LS_TOKEN_COUNT;
				end else if (st.type_letter == CH_C) begin
					status = (st.pend_err != PE_TOKENS && st.tokens == CONNECTION_FIELDS) ?
						LS_OK : LS_TOKEN_COUNT;
				end else if (st.type_letter == CH_A) begin
					status = st.name_nonempty ? LS_OK : LS_EMPTY_NAME;
				end
				emit(bd, st, RK_LINE_END, st.type_letter, 8'd0, 3'd0, 1'b0, status);
			end
			PH_DISCARD: begin
				if (st.pend_err != PE_NONE) begin
					emit(bd, st, RK_LINE_END, st.type_letter, 8'd0, 3'd0, 1'b0,
						{1'b0, st.pend_err});
				end
			end
			default: begin
			end
		endcase
		clear_line(st);
	endfunction

	// Whole step for one byte: held CR, the byte itself, then end of data
	always_comb begin
		state_t        st;
		sdplr_bundle_t bd;
		st = state_q;
		bd = '0;
		if (byte_in.data_byte == CH_LF) begin
			st.cr_held = 1'b0;
			end_line(st, bd);
		end else if (byte_in.data_byte == CH_CR) begin
			if (st.cr_held) begin
				proc_byte(st, bd, CH_CR);
			end
			st.cr_held = 1'b1;
		end else begin
			if (st.cr_held) begin
				st.cr_held = 1'b0;
				proc_byte(st, bd, CH_CR);
			end
			proc_byte(st, bd, byte_in.data_byte);
		end
		if (byte_in.end_of_data) begin
			if (st.cr_held) begin
				st.cr_held = 1'b0;
				if (st.phase == PH_START) begin
					count_line(st);
				end
			end
			if (st.phase != PH_START) begin
				end_line(st, bd);
			end
			emit(bd, st, RK_END, 8'd0, 8'd0, 3'd0, 1'b0, LS_END);
			st = STATE_RST;
		end
		if (bd.cnt != '0) begin
			bd.item[bd.cnt[$clog2(MAX_RES)-1:0] - 1'b1].last_of_run = 1'b1;
		end
		st_next = st;
		bundle  = bd;
	end

	// Parser state, updated once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (advance) begin
			state_q <= st_next;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sdplr_outq.sv
// ----------------------------------------------------------------------------
// sdplr_outq
// Holds the result bundle of one byte and hands its results to the output
// register one per cycle while the output register is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sdplr_outq
	import sdplr_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire sdplr_bundle_t bundle,
	output logic               free,
	output logic               result_valid,
	input  wire logic          result_stall,
	output sdplr_res_t         result_data
);

	logic [RES_CNT_W-1:0]     cnt_q;
	sdplr_res_t [MAX_RES-1:0] item_q;
	logic                     pop;

	// Move the head result out when the output register is empty or draining
	assign pop  = (cnt_q != '0) && (!result_valid || !result_stall);
	assign free = (cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && pop);

	// Bundle holding register, shifts down as results leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= bundle.item;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				item_q[i] <= item_q[i + 1];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (pop) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_data <= item_q[0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sdp_line_recognizer_core.sv
// ----------------------------------------------------------------------------
// sdp_line_recognizer_core
// Streaming recogniser for session description lines: one text byte in, its
// value-byte, line-end and end-of-data results out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while byte_stall is low. A byte is registered,
// parsed in one pass against the line state and its zero to four results go
// into a bundle register; the output register takes one result per cycle
// from that bundle while the output register is not stalled. The byte stall
// rises only while the bundle still holds results. A byte passes the input
// register, then its results pass the bundle register and the output register.
// last_of_run marks the final result of each byte; after an end-of-data byte
// all state, line counter included, is reset.
`default_nettype none

module sdp_line_recognizer_core
	import sdplr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire sdplr_in_t  byte_data,
	output logic            result_valid,
	input  wire logic       result_stall,
	output sdplr_res_t      result_data
);

	logic          valid_s1;
	sdplr_in_t     byte_s1;
	logic          take;
	logic          free;
	sdplr_bundle_t bundle;

	// A registered byte is consumed once the bundle register can take its results
	assign take       = valid_s1 && free;
	assign byte_stall = valid_s1 && !free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= byte_data;
		end
	end

	// Parser
	sdplr_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (take),
		.byte_in (byte_s1),
		.bundle  (bundle)
	);

	// Result bundle and output register
	sdplr_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take),
		.bundle       (bundle),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

`default_nettype wire
